[design/ctut_pkg.sv]
package ctut_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int NUM_HANDLES   = 16;
	localparam int COUNT_BITS    = 16;

	localparam int IDX_W    = $clog2(TABLE_ENTRIES);
	localparam int HANDLE_W = 4;
	localparam int CLIENT_W = 8;
	localparam int OUT_CNT_W = 16;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef logic [COUNT_BITS-1:0] cnt_t;

	localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		KIND_OPEN   = 3'd0,
		KIND_CLOSE  = 3'd1,
		KIND_REMWR  = 3'd2,
		KIND_KILL   = 3'd3,
		KIND_STATUS = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_EXEC
	} fsm_t;

	// one table record as held in the RAM
	typedef struct packed {
		logic                cached;
		cnt_t                execs;
		cnt_t                writers;
		cnt_t                refs;
		logic [CLIENT_W-1:0] client;
		logic [HANDLE_W-1:0] handle;
	} rec_t;

	// result transaction, found in the lowest bit
	typedef struct packed {
		logic [1:0]           status;
		logic                 cached;
		logic [OUT_CNT_W-1:0] exec_count;
		logic [OUT_CNT_W-1:0] write_count;
		logic [OUT_CNT_W-1:0] ref_count;
		logic                 found;
	} res_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic done;
	} stat_t;

	function automatic logic [OUT_CNT_W-1:0] cnt_to_out(cnt_t v);
		logic [31:0] w;
		w = 32'(v);
		return w[OUT_CNT_W-1:0];
	endfunction

	function automatic logic handle_in_range(logic [HANDLE_W-1:0] h);
		return 32'(h) < 32'(NUM_HANDLES);
	endfunction

endpackage

[design/client_use_count_table.sv]
// Client-use count table: associative table of per-handle, per-client use records.
// Lookup: a lookup scans the table one entry per cycle through the record RAM;
//   a hit ends the scan at the matching entry, a miss scans every entry.
// Transactions: one at a time; the next request is taken only after the result
//   is loaded into the output register, where results wait.
// Reset (arst_n low, asynchronous): all records free, no result pending.
module client_use_count_table (
	input  logic        clk,
	input  logic        arst_n,

	// request transaction
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] handle, [11:4] client_id, [12] write_flag, [13] exec_flag,
	// [14] cached_flag, [15] zero
	input  logic [15:0] s_tdata,
	// [2:0] kind
	input  logic [2:0]  s_tuser,

	// result transaction
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] found, [16:1] ref_count, [32:17] write_count, [48:33] exec_count,
	// [49] cached_out, [51:50] status, [55:52] zero
	output logic [55:0] m_tdata
);

	// Controller sequences accept -> scan -> execute; the datapath owns the
	// valid bits, the record RAM, the scan pipeline and the result register.
	ctut_pkg::cmd_t  cmd;
	ctut_pkg::stat_t stat;

	ctut_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	// Scan takes the lowest matching valid record and remembers the lowest
	// free one; the update step applies the operation and writes back at most once.
	ctut_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tdata(m_tdata)
	);

endmodule

[design/ctut_ram.sv]
module ctut_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/ctut_ctrl.sv]
module ctut_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output ctut_pkg::cmd_t  cmd,
	input  ctut_pkg::stat_t stat
);

	ctut_pkg::fsm_t state_q, state_d;
	logic           out_valid_q;
	logic           out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctut_pkg::FSM_IDLE: begin
				if (s_tvalid) state_d = ctut_pkg::FSM_SCAN;
			end
			ctut_pkg::FSM_SCAN: begin
				if (stat.hit || stat.done) state_d = ctut_pkg::FSM_EXEC;
			end
			ctut_pkg::FSM_EXEC: begin
				if (out_free) state_d = ctut_pkg::FSM_IDLE;
			end
			default: state_d = ctut_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		cmd.start = 1'b0;
		cmd.scan  = 1'b0;
		cmd.exec  = 1'b0;
		unique case (state_q)
			ctut_pkg::FSM_IDLE: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid;
			end
			ctut_pkg::FSM_SCAN: cmd.scan = 1'b1;
			ctut_pkg::FSM_EXEC: cmd.exec = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctut_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	// a result is only loaded into a free output register
	a_exec_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || m_tready))
		else $error("result loaded over a pending transaction");

	// an accepted transaction always starts a scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ctut_pkg::FSM_SCAN))
		else $error("accepted transaction did not start a scan");

	// a new result only appears right after an execute step
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ctut_pkg::FSM_EXEC))
		else $error("result raised outside execute");

endmodule

[design/ctut_dp.sv]
module ctut_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  ctut_pkg::cmd_t  cmd,
	output ctut_pkg::stat_t stat,
	input  logic [15:0]     s_tdata,
	input  logic [2:0]      s_tuser,
	output logic [55:0]     m_tdata
);

	// transaction fields
	logic [2:0]                    kind_q;
	logic [ctut_pkg::HANDLE_W-1:0] handle_q;
	logic [ctut_pkg::CLIENT_W-1:0] client_q;
	logic                          wf_q, xf_q, cf_q;

	// scan
	logic [ctut_pkg::IDX_W-1:0] addr_q;
	logic                       issue_q;
	logic                       chk_s1;
	logic [ctut_pkg::IDX_W-1:0] chk_idx_s1;
	logic                       chk_valid_s1;
	logic                       tag_hit;

	logic                       hit_q;
	logic [ctut_pkg::IDX_W-1:0] hit_idx_q;
	ctut_pkg::rec_t             rec_q;
	logic                       free_found_q;
	logic [ctut_pkg::IDX_W-1:0] free_idx_q;

	logic [ctut_pkg::TABLE_ENTRIES-1:0] valid_q;

	ctut_pkg::rec_t rd_rec;
	logic           rd_en;

	// update
	logic                       wr_en, set_v, clr_v;
	logic [ctut_pkg::IDX_W-1:0] wr_idx;
	ctut_pkg::rec_t             wr_rec;
	ctut_pkg::res_t             res_d, res_q;
	ctut_pkg::cnt_t             r0, w0, x0, nr, nw, nx;
	logic                       ovf, under, op_ok;

	assign rd_en = cmd.scan && issue_q;

	ctut_ram #(
		.WIDTH($bits(ctut_pkg::rec_t)),
		.DEPTH(ctut_pkg::TABLE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx),
		.wr_data(wr_rec),
		.rd_en  (rd_en),
		.rd_addr(addr_q),
		.rd_data(rd_rec)
	);

	assign tag_hit = cmd.scan && chk_s1 && chk_valid_s1 &&
		rd_rec.handle == handle_q && rd_rec.client == client_q;

	assign stat.hit  = tag_hit;
	assign stat.done = chk_s1 && chk_idx_s1 == ctut_pkg::LAST_IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q      <= 1'b0;
			chk_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			valid_q      <= '0;
		end else begin
			if (cmd.start) begin
				issue_q      <= 1'b1;
				chk_s1       <= 1'b0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan) begin
				chk_s1 <= issue_q;
				if (issue_q && addr_q == ctut_pkg::LAST_IDX) issue_q <= 1'b0;
				if (issue_q && !valid_q[addr_q]) free_found_q <= 1'b1;
				if (tag_hit) hit_q <= 1'b1;
			end
			if (cmd.exec) begin
				if (set_v) valid_q[wr_idx] <= 1'b1;
				if (clr_v) valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q   <= s_tuser;
			handle_q <= s_tdata[3:0];
			client_q <= s_tdata[11:4];
			wf_q     <= s_tdata[12];
			xf_q     <= s_tdata[13];
			cf_q     <= s_tdata[14];
			addr_q   <= '0;
		end else if (cmd.scan) begin
			if (issue_q) begin
				addr_q <= (addr_q == ctut_pkg::LAST_IDX) ? '0 : addr_q + 1'b1;
				if (!valid_q[addr_q] && !free_found_q) free_idx_q <= addr_q;
			end
			chk_idx_s1   <= addr_q;
			chk_valid_s1 <= valid_q[addr_q];
			if (tag_hit) begin
				hit_idx_q <= chk_idx_s1;
				rec_q     <= rd_rec;
			end
		end
		if (cmd.exec) res_q <= res_d;
	end

	assign op_ok = kind_q <= ctut_pkg::KIND_STATUS &&
		ctut_pkg::handle_in_range(handle_q);

	assign r0 = hit_q ? rec_q.refs    : '0;
	assign w0 = hit_q ? rec_q.writers : '0;
	assign x0 = hit_q ? rec_q.execs   : '0;

	always_comb begin
		res_d        = '0;
		res_d.cached = cf_q;
		res_d.status = ctut_pkg::ST_OK;
		wr_en        = 1'b0;
		set_v        = 1'b0;
		clr_v        = 1'b0;
		wr_idx       = hit_q ? hit_idx_q : free_idx_q;
		wr_rec       = rec_q;
		wr_rec.handle = handle_q;
		wr_rec.client = client_q;
		ovf   = 1'b0;
		under = 1'b0;
		nr    = r0;
		nw    = w0;
		nx    = x0;
		if (op_ok) begin
			res_d.found = hit_q;
			case (kind_q)
				ctut_pkg::KIND_OPEN: begin
					if (!hit_q && !free_found_q) begin
						res_d.status = ctut_pkg::ST_FULL;
					end else begin
						ovf = r0 == ctut_pkg::CNT_MAX ||
							(wf_q && w0 == ctut_pkg::CNT_MAX) ||
							(xf_q && x0 == ctut_pkg::CNT_MAX);
						if (r0 != ctut_pkg::CNT_MAX) nr = r0 + 1'b1;
						if (wf_q && w0 != ctut_pkg::CNT_MAX) nw = w0 + 1'b1;
						if (xf_q && x0 != ctut_pkg::CNT_MAX) nx = x0 + 1'b1;
						wr_en          = 1'b1;
						set_v          = 1'b1;
						wr_rec.refs    = nr;
						wr_rec.writers = nw;
						wr_rec.execs   = nx;
						wr_rec.cached  = cf_q;
						res_d.ref_count   = ctut_pkg::cnt_to_out(nr);
						res_d.write_count = ctut_pkg::cnt_to_out(nw);
						res_d.exec_count  = ctut_pkg::cnt_to_out(nx);
						if (ovf) res_d.status = ctut_pkg::ST_OVERFLOW;
					end
				end
				ctut_pkg::KIND_CLOSE: begin
					if (hit_q) begin
						under = r0 == '0 || (wf_q && w0 == '0) || (xf_q && x0 == '0);
						res_d.cached = rec_q.cached;
						if (under) begin
							res_d.status = ctut_pkg::ST_UNDERFLOW;
						end else begin
							nr = r0 - 1'b1;
							if (wf_q) nw = w0 - 1'b1;
							if (xf_q) nx = x0 - 1'b1;
							wr_rec.refs    = nr;
							wr_rec.writers = nw;
							wr_rec.execs   = nx;
							if ((!cf_q || !rec_q.cached) && nr == '0) begin
								clr_v        = 1'b1;
								res_d.cached = 1'b0;
							end else begin
								wr_en = 1'b1;
							end
						end
					end
				end
				ctut_pkg::KIND_REMWR: begin
					if (hit_q) begin
						if (w0 == '0) begin
							res_d.status = ctut_pkg::ST_UNDERFLOW;
						end else begin
							wr_rec.writers = w0 - 1'b1;
							wr_en          = 1'b1;
						end
					end
				end
				ctut_pkg::KIND_KILL, ctut_pkg::KIND_STATUS: begin
					if (hit_q) begin
						res_d.ref_count   = ctut_pkg::cnt_to_out(r0);
						res_d.write_count = ctut_pkg::cnt_to_out(w0);
						res_d.exec_count  = ctut_pkg::cnt_to_out(x0);
						clr_v = kind_q == ctut_pkg::KIND_KILL;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tdata = {4'b0, res_q};

	// a match is only taken from a read that was really issued
	a_hit_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> chk_s1 && chk_valid_s1)
		else $error("tag match without a pending read");

	// a record is never written and freed in the same step
	a_no_write_and_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(wr_en && clr_v))
		else $error("record written and freed together");

endmodule

[dv/client_use_count_table_tb.sv]
`timescale 1ns / 100ps

module client_use_count_table_tb;

	// kinds the block must ignore (no names for them in the package)
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 1425;
	localparam int KEY_POOL     = 40;
	// drain margin: room for two full miss scans with their pipeline
	localparam int DRAIN_CYCLES = 2 * (ctut_pkg::TABLE_ENTRIES + 4);
	localparam int RX_HOLD      = 400;
	// the cycle limit leaves wide margin over a full run, random idling and the
	// long receiver hold included
	localparam longint CYCLE_LIMIT = 3_000_000;

	// Scoreboard: keeps its own copy of the record table, predicts one result
	// per accepted request and checks results in order.
	class use_table_scoreboard;
		bit                            rec_valid[ctut_pkg::TABLE_ENTRIES];
		logic [ctut_pkg::HANDLE_W-1:0] rec_handle[ctut_pkg::TABLE_ENTRIES];
		logic [ctut_pkg::CLIENT_W-1:0] rec_client[ctut_pkg::TABLE_ENTRIES];
		ctut_pkg::cnt_t                rec_refs[ctut_pkg::TABLE_ENTRIES];
		ctut_pkg::cnt_t                rec_writers[ctut_pkg::TABLE_ENTRIES];
		ctut_pkg::cnt_t                rec_execs[ctut_pkg::TABLE_ENTRIES];
		bit                            rec_cached[ctut_pkg::TABLE_ENTRIES];

		ctut_pkg::res_t expected_q[$];
		int             errors, n_requests, n_results;
		int             n_found, n_full, n_underflow, n_overflow;

		function void bump(ref ctut_pkg::cnt_t v, ref bit ovf);
			if (v == ctut_pkg::CNT_MAX)
				ovf = 1'b1;
			else
				v = v + 1'b1;
		endfunction

		function void note_request(logic [2:0] kind, logic [15:0] data);
			logic [ctut_pkg::HANDLE_W-1:0] h;
			logic [ctut_pkg::CLIENT_W-1:0] c;
			bit             wf, xf, cf, ovf;
			int             e;
			ctut_pkg::res_t r;
			h  = data[3:0];
			c  = data[11:4];
			wf = data[12];
			xf = data[13];
			cf = data[14];
			e  = -1;
			r  = '0;
			r.cached = cf;
			r.status = ctut_pkg::ST_OK;
			n_requests++;

			if (kind <= ctut_pkg::KIND_STATUS && handle_ok(h)) begin
				// lowest matching record wins
				for (int i = 0; i < ctut_pkg::TABLE_ENTRIES; i++)
					if (e < 0 && rec_valid[i] && rec_handle[i] == h && rec_client[i] == c)
						e = i;
				r.found = (e >= 0);

				if (kind == ctut_pkg::KIND_OPEN) begin
					if (e < 0) begin
						// allocate the lowest free record
						for (int i = 0; i < ctut_pkg::TABLE_ENTRIES; i++)
							if (e < 0 && !rec_valid[i])
								e = i;
						if (e >= 0) begin
							rec_valid[e]   = 1'b1;
							rec_handle[e]  = h;
							rec_client[e]  = c;
							rec_refs[e]    = '0;
							rec_writers[e] = '0;
							rec_execs[e]   = '0;
						end
					end
					if (e < 0) begin
						r.status = ctut_pkg::ST_FULL;
					end else begin
						ovf = 1'b0;
						rec_cached[e] = cf;
						bump(rec_refs[e], ovf);
						if (wf) bump(rec_writers[e], ovf);
						if (xf) bump(rec_execs[e], ovf);
						r.ref_count   = rec_refs[e];
						r.write_count = rec_writers[e];
						r.exec_count  = rec_execs[e];
						if (ovf) r.status = ctut_pkg::ST_OVERFLOW;
					end
				end else if (e >= 0) begin
					if (kind == ctut_pkg::KIND_CLOSE) begin
						if (rec_refs[e] == 0 || (wf && rec_writers[e] == 0) ||
							(xf && rec_execs[e] == 0)) begin
							// underflow leaves the record alone
							r.status = ctut_pkg::ST_UNDERFLOW;
							r.cached = rec_cached[e];
						end else begin
							rec_refs[e] = rec_refs[e] - 1'b1;
							if (wf) rec_writers[e] = rec_writers[e] - 1'b1;
							if (xf) rec_execs[e] = rec_execs[e] - 1'b1;
							// last reference frees it unless retention asked and cached
							if ((!cf || !rec_cached[e]) && rec_refs[e] == 0) begin
								rec_valid[e] = 1'b0;
								r.cached = 1'b0;
							end else begin
								r.cached = rec_cached[e];
							end
						end
					end else if (kind == ctut_pkg::KIND_REMWR) begin
						if (rec_writers[e] == 0)
							r.status = ctut_pkg::ST_UNDERFLOW;
						else
							rec_writers[e] = rec_writers[e] - 1'b1;
					end else begin
						// kill and status report the counts as they stand
						r.ref_count   = rec_refs[e];
						r.write_count = rec_writers[e];
						r.exec_count  = rec_execs[e];
						if (kind == ctut_pkg::KIND_KILL) rec_valid[e] = 1'b0;
					end
				end
			end
			expected_q.push_back(r);
		endfunction

		function bit handle_ok(logic [ctut_pkg::HANDLE_W-1:0] h);
			return int'(h) < ctut_pkg::NUM_HANDLES;
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [55:0] data);
			ctut_pkg::res_t want, got;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %h", $time, data);
				return;
			end
			want = expected_q.pop_front();
			got  = data[51:0];
			n_results++;
			if (want.found) n_found++;
			case (want.status)
				ctut_pkg::ST_FULL:      n_full++;
				ctut_pkg::ST_UNDERFLOW: n_underflow++;
				ctut_pkg::ST_OVERFLOW:  n_overflow++;
				default: ;
			endcase
			compare_field("found", want.found, got.found);
			compare_field("ref_count", want.ref_count, got.ref_count);
			compare_field("write_count", want.write_count, got.write_count);
			compare_field("exec_count", want.exec_count, got.exec_count);
			compare_field("cached_out", want.cached, got.cached);
			compare_field("status", want.status, got.status);
			compare_field("padding", 0, data[55:52]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [3:0] handle, [11:4] client_id, [12] write, [13] exec, [14] cached
	logic [2:0]  s_tuser;   // [2:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [0] found, [16:1] refs, [32:17] writers, [48:33] execs,
	                        // [49] cached_out, [51:50] status

	int     send_idle_pct;  // chance in 100 that the sender skips a cycle
	int     recv_idle_pct;  // chance in 100 that the receiver stalls a cycle
	int     rx_hold_left;   // cycles the receiver still holds off
	longint cycle_count;

	use_table_scoreboard sb;

	client_use_count_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, sb.expected_q.size());
			$display("client_use_count_table_tb NOT OK");
			$finish;
		end
	end

	// Both handshakes are sampled at the rising edge; inputs only move on
	// the falling edge, so the values seen here are settled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
		end
	end

	// Receiver: random stalls, plus a long hold-off on request that it
	// counts down itself.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left = rx_hold_left - 1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one request and return at the falling edge after it was taken.
	// Valid stays up between back-to-back transactions.
	task automatic send_req(input logic [2:0] kind, input logic [ctut_pkg::HANDLE_W-1:0] h,
		input logic [ctut_pkg::CLIENT_W-1:0] c, input bit wf, input bit xf, input bit cf);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, cf, xf, wf, c, h};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stop offering until every outstanding result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	initial begin
		logic [ctut_pkg::HANDLE_W-1:0] pool_handle[KEY_POOL];
		logic [ctut_pkg::CLIENT_W-1:0] pool_client[KEY_POOL];
		logic [2:0]                    kind;
		logic [ctut_pkg::HANDLE_W-1:0] h;
		logic [ctut_pkg::CLIENT_W-1:0] c;
		int                            pick, slot;

		sb = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rx_hold_left  = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 53;

		// Directed: misses on an empty table, ignored kinds, then one record walked
		// through writer and reference underflows and the cached-retention path.
		send_req(ctut_pkg::KIND_STATUS, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_req(ctut_pkg::KIND_CLOSE, 4'd15, 8'd255, 1'b1, 1'b1, 1'b1);
		send_req(ctut_pkg::KIND_REMWR, 4'd15, 8'd255, 1'b0, 1'b0, 1'b0);
		send_req(ctut_pkg::KIND_KILL, 4'd0, 8'd255, 1'b0, 1'b0, 1'b1);
		for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
			send_req(3'(k), 4'd15, 8'd255, 1'b1, 1'b1, 1'b1);
		send_req(ctut_pkg::KIND_OPEN, 4'd0, 8'd0, 1'b1, 1'b1, 1'b1);
		send_req(ctut_pkg::KIND_OPEN, 4'd15, 8'd255, 1'b0, 1'b0, 1'b0);
		// same client, other handle
		send_req(ctut_pkg::KIND_OPEN, 4'd0, 8'd255, 1'b0, 1'b1, 1'b0);
		send_req(ctut_pkg::KIND_STATUS, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_req(ctut_pkg::KIND_REMWR, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		// writers already zero
		send_req(ctut_pkg::KIND_REMWR, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		// writer underflow
		send_req(ctut_pkg::KIND_CLOSE, 4'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		// last ref, kept as cached
		send_req(ctut_pkg::KIND_CLOSE, 4'd0, 8'd0, 1'b0, 1'b1, 1'b1);
		// ref underflow
		send_req(ctut_pkg::KIND_CLOSE, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_req(ctut_pkg::KIND_STATUS, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_req(ctut_pkg::KIND_KILL, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_req(ctut_pkg::KIND_STATUS, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		// retention asked, not cached
		send_req(ctut_pkg::KIND_CLOSE, 4'd15, 8'd255, 1'b0, 1'b0, 1'b1);
		send_req(ctut_pkg::KIND_CLOSE, 4'd0, 8'd255, 1'b0, 1'b1, 1'b0);
		send_req(ctut_pkg::KIND_STATUS, 4'd15, 8'd255, 1'b0, 1'b0, 1'b0);

		// Random part: mostly a small pool of keys so records get reused,
		// filled and freed; the table runs full now and then.
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_handle[i] = ctut_pkg::HANDLE_W'($urandom());
			pool_client[i] = ctut_pkg::CLIENT_W'($urandom());
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 53;
				recv_idle_pct = 24;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (i == RANDOM_ITEMS / 4 || i == 3 * RANDOM_ITEMS / 4)
				wait_drained();
			// long receiver stall while requests keep coming: backs up the block
			if (i == RANDOM_ITEMS / 2)
				rx_hold_left = RX_HOLD;

			pick = $urandom_range(99);
			if (pick < 40)
				kind = ctut_pkg::KIND_OPEN;
			else if (pick < 65)
				kind = ctut_pkg::KIND_CLOSE;
			else if (pick < 75)
				kind = ctut_pkg::KIND_REMWR;
			else if (pick < 82)
				kind = ctut_pkg::KIND_KILL;
			else if (pick < 95)
				kind = ctut_pkg::KIND_STATUS;
			else
				kind = 3'(KIND_UNUSED_FIRST +
					$urandom_range(KIND_UNUSED_LAST - KIND_UNUSED_FIRST));

			if ($urandom_range(9) == 0) begin
				h = ctut_pkg::HANDLE_W'($urandom());
				c = ctut_pkg::CLIENT_W'($urandom());
			end else begin
				slot = $urandom_range(KEY_POOL - 1);
				h = pool_handle[slot];
				c = pool_client[slot];
			end
			send_req(kind, h, c, 1'($urandom()), 1'($urandom()), 1'($urandom()));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d requests, %0d results checked; %0d hit an existing record",
			sb.n_requests, sb.n_results, sb.n_found);
		$display("table full %0d, underflow %0d, overflow %0d, mismatches %0d",
			sb.n_full, sb.n_underflow, sb.n_overflow, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("client_use_count_table_tb OK");
		else
			$display("client_use_count_table_tb NOT OK");
		$finish;
	end

endmodule

[client_use_count_table.f]
design/ctut_pkg.sv
design/ctut_ram.sv
design/ctut_ctrl.sv
design/ctut_dp.sv
design/client_use_count_table.sv
dv/client_use_count_table_tb.sv
